/* design/nor_flash_command_sequencer_unit_assert.svh */
// ----------------------------------------------------------------------------
// nor flash command sequencer assertion macros
// shared property forms for the port-level checker
// ----------------------------------------------------------------------------
`ifndef NOR_FLASH_COMMAND_SEQUENCER_UNIT_ASSERT_SVH
`define NOR_FLASH_COMMAND_SEQUENCER_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define NFCS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define NFCS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/nfcs_pkg.sv */
// ----------------------------------------------------------------------------
// nfcs_pkg
// types, codes and microcode table of the nor flash command sequencer
// ----------------------------------------------------------------------------
package nfcs_pkg;

	// request codes
	typedef enum logic [2:0] {
		REQ_READ    = 3'd0,
		REQ_PROGRAM = 3'd1,
		REQ_SECTOR  = 3'd2,
		REQ_CHIP    = 3'd3,
		REQ_ID      = 3'd4
	} req_t;

	// bus cycle kinds
	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_READ  = 2'd1,
		KIND_POLL  = 2'd2
	} kind_t;

	// low address source
	typedef enum logic [2:0] {
		ASEL_5555,
		ASEL_2AAA,
		ASEL_ADDR,
		ASEL_SADDR,
		ASEL_ZERO,
		ASEL_IDSEL
	} asel_t;

	// data source
	typedef enum logic [3:0] {
		DSEL_AA,
		DSEL_55,
		DSEL_CMD,
		DSEL_WBYTE,
		DSEL_30,
		DSEL_FF,
		DSEL_10,
		DSEL_F0,
		DSEL_ZERO
	} dsel_t;

	// sequencing of the step counter
	typedef enum logic [1:0] {
		JMP_SEQ,
		JMP_DISPATCH,
		JMP_CHIP_BR,
		JMP_END
	} jmp_t;

	typedef logic [3:0] upc_t;

	typedef struct packed {
		kind_t kind;
		asel_t asel;
		dsel_t dsel;
		jmp_t  jmp;
	} ucode_t;

	// jedec unlock addresses and command bytes
	localparam logic [15:0] ADDR_5555 = 16'h5555;
	localparam logic [15:0] ADDR_2AAA = 16'h2aaa;
	localparam logic [7:0]  CMD_AA    = 8'haa;
	localparam logic [7:0]  CMD_55    = 8'h55;
	localparam logic [7:0]  CMD_PROG  = 8'ha0;
	localparam logic [7:0]  CMD_ERASE = 8'h80;
	localparam logic [7:0]  CMD_SECT  = 8'h30;
	localparam logic [7:0]  CMD_CHIP  = 8'h10;
	localparam logic [7:0]  CMD_ID    = 8'h90;
	localparam logic [7:0]  CMD_RESET = 8'hf0;
	localparam logic [7:0]  ERASED    = 8'hff;

	// entry points of the microcode
	localparam upc_t UPC_UNLOCK    = 4'd0;
	localparam upc_t UPC_PROG      = 4'd3;
	localparam upc_t UPC_ERASE     = 4'd5;
	localparam upc_t UPC_SECT      = 4'd7;
	localparam upc_t UPC_CHIP      = 4'd9;
	localparam upc_t UPC_ID        = 4'd11;
	localparam upc_t UPC_READ      = 4'd13;

	// microcode table
	function automatic ucode_t ucode_rom(input upc_t pc);
		ucode_t w;
		unique case (pc)
			// common unlock, command byte picked per request
			4'd0:  w = '{KIND_WRITE, ASEL_5555,  DSEL_AA,    JMP_SEQ};
			4'd1:  w = '{KIND_WRITE, ASEL_2AAA,  DSEL_55,    JMP_SEQ};
			4'd2:  w = '{KIND_WRITE, ASEL_5555,  DSEL_CMD,   JMP_DISPATCH};
			// byte program
			4'd3:  w = '{KIND_WRITE, ASEL_ADDR,  DSEL_WBYTE, JMP_SEQ};
			4'd4:  w = '{KIND_POLL,  ASEL_ADDR,  DSEL_WBYTE, JMP_END};
			// second unlock of both erases
			4'd5:  w = '{KIND_WRITE, ASEL_5555,  DSEL_AA,    JMP_SEQ};
			4'd6:  w = '{KIND_WRITE, ASEL_2AAA,  DSEL_55,    JMP_CHIP_BR};
			// sector erase tail
			4'd7:  w = '{KIND_WRITE, ASEL_SADDR, DSEL_30,    JMP_SEQ};
			4'd8:  w = '{KIND_POLL,  ASEL_SADDR, DSEL_FF,    JMP_END};
			// chip erase tail
			4'd9:  w = '{KIND_WRITE, ASEL_5555,  DSEL_10,    JMP_SEQ};
			4'd10: w = '{KIND_POLL,  ASEL_ZERO,  DSEL_FF,    JMP_END};
			// read id tail
			4'd11: w = '{KIND_READ,  ASEL_IDSEL, DSEL_ZERO,  JMP_SEQ};
			4'd12: w = '{KIND_WRITE, ASEL_IDSEL, DSEL_F0,    JMP_END};
			// plain read
			4'd13: w = '{KIND_READ,  ASEL_ADDR,  DSEL_ZERO,  JMP_END};
			default: w = '{KIND_READ, ASEL_ZERO, DSEL_ZERO,  JMP_END};
		endcase
		return w;
	endfunction

endpackage

/* design/nor_flash_command_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// nor_flash_command_sequencer_unit
// turns one flash command into the bus cycles of a jedec parallel nor flash
// ----------------------------------------------------------------------------
// channel  dir  handshake          payload
// in       in   in_valid/in_stall  req_type byte_address write_byte
//                                  sector_number id_select
// out      out  out_valid/out_stall cycle_kind low_addr high_addr bus_data last
//
// a command is accepted first and then stepped through its bus cycles: read
// is one read, the others start with the unlock; unknown requests emit none.
// while no stalled result waits, the microcode step counter emits one bus
// cycle per clock into the output register; in_stall is high while a command
// is in progress. out_stall holds the step counter and the output register.
// reset clears the busy flag and output valid; no clearing pass.
// ----------------------------------------------------------------------------
module nor_flash_command_sequencer_unit #(
	parameter int SECTOR_SHIFT = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  req_type,
	input  logic [18:0] byte_address,
	input  logic [7:0]  write_byte,
	input  logic [6:0]  sector_number,
	input  logic        id_select,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  cycle_kind,
	output logic [15:0] low_addr,
	output logic [2:0]  high_addr,
	output logic [7:0]  bus_data,
	output logic        last
);
	import nfcs_pkg::*;

	logic        busy_q;
	upc_t        pc_q;
	req_t        req_q;
	logic [15:0] addr_q;
	logic [7:0]  wbyte_q;
	logic [15:0] saddr_q;
	logic        id_q;
	logic [2:0]  high_q;
	logic [7:0]  cmd_q;
	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [15:0] low_q;
	logic [2:0]  hi_out_q;
	logic [7:0]  data_q;
	logic        last_q;

	logic        accept;
	logic        step;
	logic        req_ok;
	logic [18:0] sector_addr;
	logic [7:0]  cmd_d;
	logic [2:0]  high_d;
	upc_t        entry_d;
	ucode_t      uw;
	upc_t        pc_next;
	logic [15:0] low_d;
	logic [7:0]  data_d;

	assign accept = in_valid && !in_stall;
	assign step   = busy_q && (!out_valid_q || !out_stall);
	assign in_stall = busy_q;

	// sector base address, bits above a18 dropped
	assign sector_addr = 19'({12'd0, sector_number} << SECTOR_SHIFT);

	// per-command setup decode
	always_comb begin
		req_ok  = 1'b1;
		cmd_d   = 8'd0;
		high_d  = 3'd0;
		entry_d = UPC_UNLOCK;
		unique case (req_type)
			REQ_READ: begin
				high_d  = byte_address[18:16];
				entry_d = UPC_READ;
			end
			REQ_PROGRAM: begin
				high_d = byte_address[18:16];
				cmd_d  = CMD_PROG;
			end
			REQ_SECTOR: begin
				high_d = sector_addr[18:16];
				cmd_d  = CMD_ERASE;
			end
			REQ_CHIP: begin
				cmd_d = CMD_ERASE;
			end
			REQ_ID: begin
				cmd_d = CMD_ID;
			end
			default: begin
				req_ok = 1'b0;
			end
		endcase
	end

	// latch the command transaction
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= req_t'(req_type);
			addr_q  <= byte_address[15:0];
			wbyte_q <= write_byte;
			saddr_q <= sector_addr[15:0];
			id_q    <= id_select;
			high_q  <= high_d;
			cmd_q   <= cmd_d;
		end
	end

	// microcode fetch and next step
	always_comb begin
		uw = ucode_rom(pc_q);
		pc_next = pc_q + 4'd1;
		unique case (uw.jmp)
			JMP_SEQ: pc_next = pc_q + 4'd1;
			JMP_DISPATCH: begin
				unique case (req_q)
					REQ_PROGRAM: pc_next = UPC_PROG;
					REQ_ID:      pc_next = UPC_ID;
					default:     pc_next = UPC_ERASE;
				endcase
			end
			JMP_CHIP_BR: pc_next = (req_q == REQ_CHIP) ? UPC_CHIP : UPC_SECT;
			JMP_END:     pc_next = pc_q;
			default:     pc_next = pc_q;
		endcase
	end

	// datapath selection
	always_comb begin
		unique case (uw.asel)
			ASEL_5555:  low_d = ADDR_5555;
			ASEL_2AAA:  low_d = ADDR_2AAA;
			ASEL_ADDR:  low_d = addr_q;
			ASEL_SADDR: low_d = saddr_q;
			ASEL_IDSEL: low_d = {15'd0, id_q};
			default:    low_d = 16'd0;
		endcase
		unique case (uw.dsel)
			DSEL_AA:    data_d = CMD_AA;
			DSEL_55:    data_d = CMD_55;
			DSEL_CMD:   data_d = cmd_q;
			DSEL_WBYTE: data_d = wbyte_q;
			DSEL_30:    data_d = CMD_SECT;
			DSEL_FF:    data_d = ERASED;
			DSEL_10:    data_d = CMD_CHIP;
			DSEL_F0:    data_d = CMD_RESET;
			default:    data_d = 8'd0;
		endcase
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pc_q        <= UPC_UNLOCK;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= req_ok;
				pc_q   <= entry_d;
			end else if (step) begin
				pc_q <= pc_next;
				if (uw.jmp == JMP_END) begin
					busy_q <= 1'b0;
				end
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (step) begin
			kind_q   <= uw.kind;
			low_q    <= low_d;
			hi_out_q <= high_q;
			data_q   <= data_d;
			last_q   <= (uw.jmp == JMP_END);
		end
	end

	assign out_valid  = out_valid_q;
	assign cycle_kind = kind_q;
	assign low_addr   = low_q;
	assign high_addr  = hi_out_q;
	assign bus_data   = data_q;
	assign last       = last_q;

endmodule

/* design/nfcs_checker.sv */
// ----------------------------------------------------------------------------
// nfcs_checker
// port-level checks of the nor flash command sequencer
// ----------------------------------------------------------------------------
`include "nor_flash_command_sequencer_unit_assert.svh"

module nfcs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [2:0]  req_type,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  cycle_kind,
	input logic [15:0] low_addr,
	input logic [2:0]  high_addr,
	input logic [7:0]  bus_data,
	input logic        last
);
	import nfcs_pkg::*;

	// stalled result holds
	`NFCS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(cycle_kind) && $stable(low_addr) && $stable(high_addr) && $stable(bus_data) && $stable(last), "stalled result changed")

	// a taken non-final cycle is followed at once by the next one
	`NFCS_ASSERT_NEXT(a_no_gap, out_valid && !out_stall && !last, out_valid, "gap inside a command")

	// a known command blocks further commands
	`NFCS_ASSERT_NEXT(a_busy, in_valid && !in_stall && (req_type == REQ_READ || req_type == REQ_PROGRAM || req_type == REQ_SECTOR || req_type == REQ_CHIP || req_type == REQ_ID), in_stall, "command accepted without going busy")

	// polls only close a command
	`NFCS_ASSERT_SAME(a_poll_last, out_valid && cycle_kind == KIND_POLL, last, "poll cycle not final")

endmodule

bind nor_flash_command_sequencer_unit nfcs_checker u_nfcs_checker (.*);
